[hw/rtl/cbor_token_encoder_core_defines.svh]
// assertion macros shared by the cbor token encoder rtl
// expects signals named clock and reset in the scope of use
`ifndef CBOR_TOKEN_ENCODER_CORE_DEFINES_SVH
`define CBOR_TOKEN_ENCODER_CORE_DEFINES_SVH

// checked on every edge outside reset
`define CTE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define CTE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hw/rtl/cte_pkg.sv]
// shared types and constants for the cbor token encoder
// no dependencies
package cte_pkg;

   localparam int PosBits      = 32;
   localparam int WideBits     = ((PosBits > 32) ? PosBits : 32) + 1;
   localparam int QueueDepth   = 4;
   localparam int QueuePtrBits = $clog2(QueueDepth);
   localparam int QueueCntBits = $clog2(QueueDepth + 1);
   localparam int CsrIndexBits = 1;

   typedef enum logic [4:0] {
      ACT_FALSE    = 5'd0,
      ACT_TRUE     = 5'd1,
      ACT_NULL     = 5'd2,
      ACT_UNDEF    = 5'd3,
      ACT_UINT     = 5'd4,
      ACT_NEGINT   = 5'd5,
      ACT_BYTES    = 5'd6,
      ACT_TEXT     = 5'd7,
      ACT_CHBYTES  = 5'd8,
      ACT_CHTEXT   = 5'd9,
      ACT_ARRAY    = 5'd10,
      ACT_MAP      = 5'd11,
      ACT_TAG      = 5'd12,
      ACT_SIMPLE   = 5'd13,
      ACT_DOUBLE   = 5'd14,
      ACT_INVALID  = 5'd15,
      ACT_BREAK    = 5'd16,
      ACT_PAYLOAD  = 5'd17,
      ACT_BEGIN    = 5'd18,
      ACT_FINISH   = 5'd19
   } action_type;

   localparam logic [CsrIndexBits-1:0] CSR_BUFFER_SIZE  = 1'd0;
   localparam logic [CsrIndexBits-1:0] CSR_START_OFFSET = 1'd1;

   typedef struct packed {
      logic [4:0]  action;
      logic [63:0] value;
      logic        indefinite;
      logic [7:0]  data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        is_report;
      logic [31:0] encoded_length;
      logic        failed;
      logic        last;
   } rsp_payload_type;

   // one queued job: a head byte followed by count-1 bytes taken from the top of tail
   typedef struct packed {
      logic [7:0]       head_byte;
      logic [7:0][7:0]  tail;
      logic [3:0]       count;
      logic             is_report;
      logic [31:0]      encoded_length;
      logic             failed;
   } cmd_type;

endpackage

[hw/rtl/cte_front.sv]
// front end: token decode, buffer room check, write position and error state
// depends on cte_pkg and cbor_token_encoder_core_defines.svh
`include "cbor_token_encoder_core_defines.svh"

module cte_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  cte_pkg::req_payload_type      req_payload,
   input  logic                          q_full,
   output logic                          push,
   output cte_pkg::cmd_type              push_cmd,
   input  logic                          csr_we,
   input  logic [cte_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [31:0]                   csr_wdata
);
   import cte_pkg::*;

   typedef enum logic [2:0] {
      K_NONE, K_ONE, K_HEAD, K_DBL, K_REP, K_BEGIN, K_INV
   } kind_type;

   localparam logic [2:0] MAJ_UINT   = 3'd0;
   localparam logic [2:0] MAJ_NEGINT = 3'd1;
   localparam logic [2:0] MAJ_BYTES  = 3'd2;
   localparam logic [2:0] MAJ_TEXT   = 3'd3;
   localparam logic [2:0] MAJ_ARRAY  = 3'd4;
   localparam logic [2:0] MAJ_MAP    = 3'd5;
   localparam logic [2:0] MAJ_TAG    = 3'd6;
   localparam logic [2:0] MAJ_SIMPLE = 3'd7;

   localparam logic [4:0] AI_U8  = 5'd24;
   localparam logic [4:0] AI_U16 = 5'd25;
   localparam logic [4:0] AI_U32 = 5'd26;
   localparam logic [4:0] AI_U64 = 5'd27;

   localparam logic [7:0] BYTE_FALSE   = 8'hF4;
   localparam logic [7:0] BYTE_TRUE    = 8'hF5;
   localparam logic [7:0] BYTE_NULL    = 8'hF6;
   localparam logic [7:0] BYTE_UNDEF   = 8'hF7;
   localparam logic [7:0] BYTE_CHBYTES = 8'h5F;
   localparam logic [7:0] BYTE_CHTEXT  = 8'h7F;
   localparam logic [7:0] BYTE_IARRAY  = 8'h9F;
   localparam logic [7:0] BYTE_IMAP    = 8'hBF;
   localparam logic [7:0] BYTE_DOUBLE  = 8'hFB;
   localparam logic [7:0] BYTE_BREAK   = 8'hFF;

   logic [PosBits-1:0]  wp_ff, wp_in;
   logic                err_ff, err_in;
   logic [31:0]         bsize_ff, bsize_in;
   logic [31:0]         soff_ff, soff_in;

   kind_type            kind;
   logic [7:0]          one_byte;
   logic [2:0]          major;
   logic [63:0]         hv;
   logic [7:0]          hb;
   logic [7:0][7:0]     tail;
   logic [3:0]          n;
   logic [WideBits-1:0] need;
   logic                fits;
   logic                accept;
   logic [31:0]         rep_len;

   assign accept = req_valid && !q_full;

   // decode the token into a kind, a major type and the head argument
   always_comb begin
      kind     = K_NONE;
      one_byte = BYTE_BREAK;
      major    = MAJ_UINT;
      hv       = req_payload.value;
      unique case (action_type'(req_payload.action))
         ACT_FALSE:   begin kind = K_ONE; one_byte = BYTE_FALSE; end
         ACT_TRUE:    begin kind = K_ONE; one_byte = BYTE_TRUE; end
         ACT_NULL:    begin kind = K_ONE; one_byte = BYTE_NULL; end
         ACT_UNDEF:   begin kind = K_ONE; one_byte = BYTE_UNDEF; end
         ACT_UINT:    begin kind = K_HEAD; major = MAJ_UINT; end
         ACT_NEGINT:  begin
            kind  = K_HEAD;
            major = MAJ_NEGINT;
            hv    = ~req_payload.value;
         end
         ACT_BYTES:   begin kind = K_HEAD; major = MAJ_BYTES; end
         ACT_TEXT:    begin kind = K_HEAD; major = MAJ_TEXT; end
         ACT_CHBYTES: begin kind = K_ONE; one_byte = BYTE_CHBYTES; end
         ACT_CHTEXT:  begin kind = K_ONE; one_byte = BYTE_CHTEXT; end
         ACT_ARRAY:   begin
            if (req_payload.indefinite) begin
               kind     = K_ONE;
               one_byte = BYTE_IARRAY;
            end else begin
               kind  = K_HEAD;
               major = MAJ_ARRAY;
            end
         end
         ACT_MAP:     begin
            if (req_payload.indefinite) begin
               kind     = K_ONE;
               one_byte = BYTE_IMAP;
            end else begin
               // map heads carry the pair count
               kind  = K_HEAD;
               major = MAJ_MAP;
               hv    = {1'b0, req_payload.value[63:1]};
            end
         end
         ACT_TAG:     begin kind = K_HEAD; major = MAJ_TAG; end
         ACT_SIMPLE:  begin kind = K_HEAD; major = MAJ_SIMPLE; end
         ACT_DOUBLE:  kind = K_DBL;
         ACT_BREAK:   begin kind = K_ONE; one_byte = BYTE_BREAK; end
         ACT_PAYLOAD: begin kind = K_ONE; one_byte = req_payload.data_byte; end
         ACT_BEGIN:   kind = K_BEGIN;
         ACT_FINISH:  kind = K_REP;
         default:     kind = K_INV;
      endcase
   end

   // shortest head form, argument bytes left aligned in tail
   always_comb begin
      hb   = one_byte;
      tail = '0;
      n    = 4'd1;
      unique case (kind)
         K_HEAD: begin
            priority if (hv < 64'd24) begin
               hb = {major, hv[4:0]};
            end else if (hv < 64'd256) begin
               hb = {major, AI_U8};
               n  = 4'd2;
               tail = hv << 56;
            end else if (hv < 64'd65536) begin
               hb = {major, AI_U16};
               n  = 4'd3;
               tail = hv << 48;
            end else if (hv < 64'h1_0000_0000) begin
               hb = {major, AI_U32};
               n  = 4'd5;
               tail = hv << 32;
            end else begin
               hb = {major, AI_U64};
               n  = 4'd9;
               tail = hv;
            end
         end
         K_DBL: begin
            hb   = BYTE_DOUBLE;
            n    = 4'd9;
            tail = req_payload.value;
         end
         K_REP: hb = 8'h00;
         K_NONE, K_ONE, K_BEGIN, K_INV: hb = one_byte;
      endcase
   end

   assign need    = WideBits'(wp_ff) + WideBits'(n);
   assign fits    = need < WideBits'(bsize_ff);
   assign rep_len = err_ff ? 32'd0
                           : 32'(WideBits'(wp_ff) - WideBits'(soff_ff));

   always_comb begin
      wp_in    = wp_ff;
      err_in   = err_ff;
      bsize_in = bsize_ff;
      soff_in  = soff_ff;
      push     = 1'b0;
      push_cmd.head_byte      = hb;
      push_cmd.tail           = tail;
      push_cmd.count          = n;
      push_cmd.is_report      = 1'b0;
      push_cmd.encoded_length = 32'd0;
      push_cmd.failed         = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BUFFER_SIZE:  bsize_in = csr_wdata;
            CSR_START_OFFSET: soff_in  = csr_wdata;
         endcase
      end
      if (accept) begin
         unique case (kind)
            K_BEGIN: begin
               wp_in  = PosBits'(soff_ff);
               err_in = 1'b0;
            end
            K_INV: err_in = 1'b1;
            K_REP: begin
               push = 1'b1;
               push_cmd.is_report      = 1'b1;
               push_cmd.encoded_length = rep_len;
               push_cmd.failed         = err_ff;
            end
            K_ONE, K_HEAD, K_DBL: begin
               // the whole token must leave one byte free
               if (!err_ff) begin
                  if (fits) begin
                     push  = 1'b1;
                     wp_in = PosBits'(need);
                  end else begin
                     err_in = 1'b1;
                  end
               end
            end
            K_NONE: err_in = err_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         err_ff   <= 1'b0;
         bsize_ff <= 32'd256;
         soff_ff  <= 32'd0;
      end else begin
         wp_ff    <= wp_in;
         err_ff   <= err_in;
         bsize_ff <= bsize_in;
         soff_ff  <= soff_in;
      end
   end

   `CTE_ASSERT(a_no_err_push, (push && !push_cmd.is_report) |-> !err_ff, "push in error")
   `CTE_ASSERT(a_begin_clears, (accept && (kind == K_BEGIN)) |=> !err_ff, "begin kept error")

endmodule

[hw/rtl/cte_queue.sv]
// small job queue between the front end and the byte serializer
// depends on cte_pkg and cbor_token_encoder_core_defines.svh
`include "cbor_token_encoder_core_defines.svh"

module cte_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cte_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output cte_pkg::cmd_type head_cmd
);
   import cte_pkg::*;

   cmd_type                  mem_ff [QueueDepth];
   logic [QueuePtrBits-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrBits-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QueueCntBits-1:0]  count_ff, count_in;

   assign full       = count_ff == QueueCntBits'(QueueDepth);
   assign head_valid = count_ff != '0;
   assign head_cmd   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? QueuePtrBits'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QueuePtrBits'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `CTE_ASSERT(a_no_overflow, push |-> (!full || pop), "push into a full queue")
   `CTE_ASSERT(a_no_underflow, pop |-> head_valid, "pop from an empty queue")

endmodule

[hw/rtl/cte_back.sv]
// back end: serializes one queued job into result bytes, one per cycle unless rsp_stall holds
// depends on cte_pkg and cbor_token_encoder_core_defines.svh
`include "cbor_token_encoder_core_defines.svh"

module cte_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  cte_pkg::cmd_type         head_cmd,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output cte_pkg::rsp_payload_type rsp_payload
);
   import cte_pkg::*;

   logic [3:0]       idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_payload_ff, rsp_payload_in;
   logic             fire;
   logic             is_last;
   logic [2:0]       sel;
   logic [7:0]       cur_byte;

   assign fire    = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign is_last = idx_ff == (head_cmd.count - 4'd1);
   // argument bytes come from the top of tail downward
   assign sel      = 3'd7 - 3'(idx_ff - 4'd1);
   assign cur_byte = (idx_ff == 4'd0) ? head_cmd.head_byte : head_cmd.tail[sel];
   assign pop      = fire && is_last;

   always_comb begin
      idx_in         = idx_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (fire) begin
         idx_in       = is_last ? 4'd0 : idx_ff + 4'd1;
         rsp_valid_in = 1'b1;
         rsp_payload_in.out_byte       = cur_byte;
         rsp_payload_in.is_report      = head_cmd.is_report;
         rsp_payload_in.encoded_length = head_cmd.encoded_length;
         rsp_payload_in.failed         = head_cmd.failed;
         rsp_payload_in.last           = is_last;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
      if (reset) begin
         idx_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `CTE_ASSERT(a_report_is_last, (rsp_valid_ff && rsp_payload_ff.is_report) |-> rsp_payload_ff.last, "report not marked last")
   `CTE_ASSERT(a_index_in_range, head_valid |-> (idx_ff < head_cmd.count), "byte index past job length")

endmodule

[hw/rtl/cbor_token_encoder_core.sv]
// cbor token encoder: a request is accepted in any cycle the job queue has room
// and one result byte leaves per cycle unless rsp_stall holds; a request passes the job queue
// and the output register before its first result is valid; head and double tokens go out a byte at a time, up to nine
// reset (synchronous) clears position, error, queue and output; buffer size 256
// depends on cte_pkg, cte_front, cte_queue, cte_back
module cbor_token_encoder_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  cte_pkg::req_payload_type           req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output cte_pkg::rsp_payload_type           rsp_payload,
   input  logic                               csr_we,
   input  logic [cte_pkg::CsrIndexBits-1:0]   csr_index,
   input  logic [31:0]                        csr_wdata
);
   import cte_pkg::*;

   logic    q_full;
   logic    push;
   logic    pop;
   logic    head_valid;
   cmd_type push_cmd;
   cmd_type head_cmd;

   assign req_stall = q_full;

   cte_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .q_full      (q_full),
      .push        (push),
      .push_cmd    (push_cmd),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   cte_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   cte_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

[bench/cte_scoreboard_pkg.sv]
// scoreboard for the cbor token encoder bench: byte-level predictor and result checker
// depends on cte_pkg for the request and result payload types and the action codes
package cte_scoreboard_pkg;
   import cte_pkg::*;

   // initial bytes of the fixed one-byte items
   localparam logic [7:0] CODE_FALSE     = 8'hF4;
   localparam logic [7:0] CODE_TRUE      = 8'hF5;
   localparam logic [7:0] CODE_NULL      = 8'hF6;
   localparam logic [7:0] CODE_UNDEFINED = 8'hF7;
   localparam logic [7:0] CODE_CHBYTES   = 8'h5F;
   localparam logic [7:0] CODE_CHTEXT    = 8'h7F;
   localparam logic [7:0] CODE_ARRAY_IND = 8'h9F;
   localparam logic [7:0] CODE_MAP_IND   = 8'hBF;
   localparam logic [7:0] CODE_DOUBLE    = 8'hFB;
   localparam logic [7:0] CODE_STOP      = 8'hFF;

   // major type bits of the head forms
   localparam logic [7:0] MT_UINT   = 8'h00;
   localparam logic [7:0] MT_NEGINT = 8'h20;
   localparam logic [7:0] MT_BYTES  = 8'h40;
   localparam logic [7:0] MT_TEXT   = 8'h60;
   localparam logic [7:0] MT_ARRAY  = 8'h80;
   localparam logic [7:0] MT_MAP    = 8'hA0;
   localparam logic [7:0] MT_TAG    = 8'hC0;
   localparam logic [7:0] MT_SIMPLE = 8'hE0;

   // additional info codes for the 1, 2, 4 and 8 byte arguments
   localparam logic [7:0] AI_ONE   = 8'd24;
   localparam logic [7:0] AI_TWO   = 8'd25;
   localparam logic [7:0] AI_FOUR  = 8'd26;
   localparam logic [7:0] AI_EIGHT = 8'd27;

   class encoder_scoreboard;
      logic [31:0]     buffer_size;
      logic [31:0]     start_offset;
      logic [31:0]     write_pos;
      bit              sticky_error;
      rsp_payload_type expected_bytes[$];
      logic [7:0]      encoding[9];
      int              encoding_len;
      int              mismatches;

      function new();
         buffer_size  = 32'd256;
         start_offset = '0;
         write_pos    = '0;
         sticky_error = 1'b0;
         mismatches   = 0;
      endfunction

      function void set_config(logic [CsrIndexBits-1:0] index, logic [31:0] data);
         if (index == CSR_BUFFER_SIZE)
            buffer_size = data;
         else if (index == CSR_START_OFFSET)
            start_offset = data;
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      function void one_byte(logic [7:0] b);
         encoding[0]  = b;
         encoding_len = 1;
      endfunction

      // shortest head: argument in the initial byte, or 1, 2, 4, 8 bytes big-endian
      function void build_head(logic [7:0] major, logic [63:0] arg);
         int extra;
         if (arg < 64'd24) begin
            one_byte(major | arg[7:0]);
            return;
         end
         if (arg < 64'd256) begin
            extra = 1;
            encoding[0] = major | AI_ONE;
         end else if (arg < 64'd65536) begin
            extra = 2;
            encoding[0] = major | AI_TWO;
         end else if (arg < 64'h1_0000_0000) begin
            extra = 4;
            encoding[0] = major | AI_FOUR;
         end else begin
            extra = 8;
            encoding[0] = major | AI_EIGHT;
         end
         for (int i = 0; i < extra; i++)
            encoding[1 + i] = 8'(arg >> (8 * (extra - 1 - i)));
         encoding_len = extra + 1;
      endfunction

      // the whole token must fit with one byte to spare, else nothing goes out
      function void commit();
         rsp_payload_type e;
         if (sticky_error)
            return;
         if (({1'b0, write_pos} + 33'(encoding_len)) >= {1'b0, buffer_size}) begin
            sticky_error = 1'b1;
            return;
         end
         for (int i = 0; i < encoding_len; i++) begin
            e = '0;
            e.out_byte = encoding[i];
            e.last     = (i == encoding_len - 1);
            expected_bytes.push_back(e);
         end
         write_pos = write_pos + 32'(encoding_len);
      endfunction

      function void note_request(req_payload_type r);
         rsp_payload_type e;
         case (r.action)
            ACT_FALSE:   one_byte(CODE_FALSE);
            ACT_TRUE:    one_byte(CODE_TRUE);
            ACT_NULL:    one_byte(CODE_NULL);
            ACT_UNDEF:   one_byte(CODE_UNDEFINED);
            ACT_UINT:    build_head(MT_UINT, r.value);
            ACT_NEGINT:  build_head(MT_NEGINT, ~r.value);
            ACT_BYTES:   build_head(MT_BYTES, r.value);
            ACT_TEXT:    build_head(MT_TEXT, r.value);
            ACT_CHBYTES: one_byte(CODE_CHBYTES);
            ACT_CHTEXT:  one_byte(CODE_CHTEXT);
            ACT_ARRAY: begin
               if (r.indefinite)
                  one_byte(CODE_ARRAY_IND);
               else
                  build_head(MT_ARRAY, r.value);
            end
            ACT_MAP: begin
               if (r.indefinite)
                  one_byte(CODE_MAP_IND);
               else
                  build_head(MT_MAP, r.value >> 1);
            end
            ACT_TAG:     build_head(MT_TAG, r.value);
            ACT_SIMPLE:  build_head(MT_SIMPLE, r.value);
            ACT_DOUBLE: begin
               encoding[0] = CODE_DOUBLE;
               for (int i = 0; i < 8; i++)
                  encoding[1 + i] = 8'(r.value >> (8 * (7 - i)));
               encoding_len = 9;
            end
            ACT_BREAK:   one_byte(CODE_STOP);
            ACT_PAYLOAD: one_byte(r.data_byte);
            ACT_BEGIN: begin
               write_pos    = start_offset;
               sticky_error = 1'b0;
               return;
            end
            ACT_FINISH: begin
               e = '0;
               e.is_report      = 1'b1;
               e.encoded_length = sticky_error ? 32'd0 : write_pos - start_offset;
               e.failed         = sticky_error;
               e.last           = 1'b1;
               expected_bytes.push_back(e);
               return;
            end
            // invalid token and the unused codes above finish
            default: begin
               sticky_error = 1'b1;
               return;
            end
         endcase
         commit();
      endfunction

      function void report(string what, rsp_payload_type want, rsp_payload_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("%s: want %h/%b/%h/%b/%b got %h/%b/%h/%b/%b", what,
                     want.out_byte, want.is_report, want.encoded_length, want.failed,
                     want.last, got.out_byte, got.is_report, got.encoded_length,
                     got.failed, got.last);
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_bytes.size() == 0) begin
            report("result with nothing pending", '0, got);
            return;
         end
         want = expected_bytes.pop_front();
         if (got.out_byte !== want.out_byte || got.is_report !== want.is_report ||
             got.encoded_length !== want.encoded_length || got.failed !== want.failed ||
             got.last !== want.last)
            report("result mismatch", want, got);
      endfunction
   endclass

endpackage

[bench/cbor_token_encoder_core_test.sv]
// top-level bench for cbor_token_encoder_core: directed and random token streams under
// random request gaps and result stalls; depends on cte_pkg and cte_scoreboard_pkg
module cbor_token_encoder_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import cte_pkg::*;
   import cte_scoreboard_pkg::*;

   localparam int SettleCycles = 12;
   localparam int PhaseCount   = 9;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   req_payload_type         req_payload;
   logic                    rsp_valid;
   logic                    rsp_stall;
   rsp_payload_type         rsp_payload;
   logic                    csr_we;
   logic [CsrIndexBits-1:0] csr_index;
   logic [31:0]             csr_wdata;

   encoder_scoreboard book;
   bit                gaps_on;
   bit                stalls_on;
   int                stall_left;

   cbor_token_encoder_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("cbor_token_encoder_core test failed");
      $finish;
   end

   // result side: check on accept, then pick the stall for the next edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         book.check_result(rsp_payload);
      if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 16);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic req_payload_type make_token(action_type act, logic [63:0] arg,
                                                  bit indef, logic [7:0] data);
      req_payload_type t;
      t.action     = act;
      t.value      = arg;
      t.indefinite = indef;
      t.data_byte  = data;
      return t;
   endfunction

   function automatic req_payload_type random_token();
      req_payload_type t;
      int pick;
      t.value = {$urandom, $urandom};
      case ($urandom_range(0, 4))
         0: t.value &= 64'h1F;
         1: t.value &= 64'hFF;
         2: t.value &= 64'hFFFF;
         3: t.value &= 64'hFFFF_FFFF;
         default: ;
      endcase
      t.indefinite = 1'($urandom_range(0, 1));
      t.data_byte  = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 1)
         t.action = $urandom_range(0, 1) ? 5'(ACT_INVALID) : 5'($urandom_range(20, 31));
      else if (pick < 4)
         t.action = 5'($urandom_range(0, 31));
      else if (pick < 30)
         t.action = ACT_PAYLOAD;
      else begin
         t.action = 5'($urandom_range(0, 15));
         if (t.action == ACT_INVALID)
            t.action = ACT_BREAK;
      end
      return t;
   endfunction

   task automatic send_request(req_payload_type t);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= t;
      do @(posedge clock); while (req_stall);
      book.note_request(t);
   endtask

   // hold off requests until every expected result is out, then let silent tokens settle
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic program_csr(logic [31:0] size, logic [31:0] offset);
      csr_we    <= 1'b1;
      csr_index <= CSR_BUFFER_SIZE;
      csr_wdata <= size;
      @(posedge clock);
      book.set_config(CSR_BUFFER_SIZE, size);
      csr_index <= CSR_START_OFFSET;
      csr_wdata <= offset;
      @(posedge clock);
      book.set_config(CSR_START_OFFSET, offset);
      csr_we <= 1'b0;
   endtask

   task automatic run_sequence(bit skip_begin, int count);
      if (!skip_begin)
         send_request(make_token(ACT_BEGIN, '0, 1'b0, '0));
      for (int i = 0; i < count; i++) begin
         send_request(random_token());
         if ($urandom_range(0, 29) == 0)
            wait_for_results();
      end
      send_request(make_token(ACT_FINISH, '0, 1'b0, '0));
   endtask

   logic [31:0] sizes   [PhaseCount];
   logic [31:0] offsets [PhaseCount];

   initial begin
      req_payload_type directed[$];

      book        = new();
      gaps_on     = 1'b1;
      stalls_on   = 1'b1;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_we      <= 1'b0;
      csr_index   <= '0;
      csr_wdata   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // runs on the reset register values; first token goes out before any begin
      directed.push_back(make_token(ACT_UINT, 64'd23, 1'b0, '0));
      directed.push_back(make_token(ACT_BEGIN, '0, 1'b0, '0));
      directed.push_back(make_token(ACT_FALSE, '0, 1'b0, '0));
      directed.push_back(make_token(ACT_TRUE, '0, 1'b0, '0));
      directed.push_back(make_token(ACT_NULL, '0, 1'b0, '0));
      directed.push_back(make_token(ACT_UNDEF, '0, 1'b0, '0));
      directed.push_back(make_token(ACT_UINT, 64'd24, 1'b0, '0));
      directed.push_back(make_token(ACT_UINT, 64'd65535, 1'b0, '0));
      directed.push_back(make_token(ACT_UINT, 64'd65536, 1'b0, '0));
      directed.push_back(make_token(ACT_UINT, '1, 1'b0, '0));
      directed.push_back(make_token(ACT_NEGINT, '1, 1'b0, '0));
      // non-negative pattern: complement is large, nine-byte head
      directed.push_back(make_token(ACT_NEGINT, 64'd5, 1'b0, '0));
      directed.push_back(make_token(ACT_BYTES, 64'd255, 1'b0, '0));
      directed.push_back(make_token(ACT_TEXT, 64'hFFFF_FFFF, 1'b0, '0));
      directed.push_back(make_token(ACT_CHBYTES, '0, 1'b0, '0));
      directed.push_back(make_token(ACT_CHTEXT, '0, 1'b0, '0));
      directed.push_back(make_token(ACT_ARRAY, 64'd256, 1'b0, '0));
      directed.push_back(make_token(ACT_ARRAY, '0, 1'b1, '0));
      directed.push_back(make_token(ACT_MAP, 64'h1_0000_0001, 1'b0, '0));
      directed.push_back(make_token(ACT_MAP, '0, 1'b1, '0));
      directed.push_back(make_token(ACT_TAG, 64'h1_0000_0000, 1'b0, '0));
      directed.push_back(make_token(ACT_SIMPLE, 64'd24, 1'b0, '0));
      directed.push_back(make_token(ACT_DOUBLE, 64'hA5C3_0F81_7E3C_5A01, 1'b0, '0));
      directed.push_back(make_token(ACT_BREAK, '0, 1'b0, '0));
      directed.push_back(make_token(ACT_PAYLOAD, '0, 1'b0, 8'hFF));
      directed.push_back(make_token(ACT_FINISH, '0, 1'b0, '0));
      // invalid token, then a token under the sticky error, then the failed report
      directed.push_back(make_token(ACT_INVALID, '0, 1'b0, '0));
      directed.push_back(make_token(ACT_UINT, 64'd1, 1'b0, '0));
      directed.push_back(make_token(ACT_FINISH, '0, 1'b0, '0));
      foreach (directed[i])
         send_request(directed[i]);
      wait_for_results();

      // unused code acts as invalid
      send_request(make_token(ACT_BEGIN, '0, 1'b0, '0));
      send_request(make_token(action_type'(5'd31), '1, 1'b1, 8'hFF));
      send_request(make_token(ACT_FINISH, '0, 1'b0, '0));

      sizes   = '{32'd256, 32'd0, 32'd1, 32'd40, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'd300, 32'd0, 32'd0};
      offsets = '{32'd0, 32'd0, 32'd0, 32'd7, 32'hFFFF_FFF0, 32'hFFFF_FFFF,
                  32'd100, 32'd0, 32'd0};
      sizes[7]   = $urandom_range(64, 600);
      offsets[7] = $urandom_range(0, 50);
      sizes[8]   = 32'd4096;
      offsets[8] = $urandom;

      for (int p = 0; p < PhaseCount; p++) begin
         wait_for_results();
         program_csr(sizes[p], offsets[p]);
         gaps_on   = (p != PhaseCount - 1) && ($urandom_range(0, 3) != 0);
         stalls_on = (p != PhaseCount - 1) && ($urandom_range(0, 3) != 0);
         // phase 5 changes the offset and reports without a new begin; others may at random
         run_sequence(p == 5 || $urandom_range(0, 7) == 0, $urandom_range(14, 24));
      end

      wait_for_results();
      if (book.mismatches == 0 && book.pending() == 0)
         $display("cbor_token_encoder_core test passed");
      else
         $display("cbor_token_encoder_core test failed");
      $finish;
   end

endmodule
